// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared widths, opcodes, status codes and defaults for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK_HEAD = 3'd4;
    localparam logic [OP_W-1:0] OP_PEEK_TAIL = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic exec;
    } dq_cmd_t;

endpackage

// File: rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels carrying queue requests and queue results.
// ----------------------------------------------------------------------------
interface dq_req_if;
    logic                        valid;
    logic                        ready;
    logic [dq_pkg::OP_W-1:0]     opcode;
    logic [dq_pkg::WORD_W-1:0]   push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface dq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [dq_pkg::WORD_W-1:0]    read_value;
    logic [dq_pkg::STATUS_W-1:0]  status;
    logic                         now_empty;
    logic [dq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output read_value, output status, output now_empty,
                    output occupancy, input ready);
    modport sink   (input valid, input read_value, input status, input now_empty,
                    input occupancy, output ready);
endinterface

// File: rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int WIDTH = dq_pkg::DATA_WIDTH_DEFAULT,
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: takes one request, executes it, then holds the result.
// ----------------------------------------------------------------------------
module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output dq_pkg::dq_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign cmd.load  = in_valid && (state_reg == S_IDLE);
    assign cmd.exec  = (state_reg == S_EXEC);

endmodule

// File: rtl/dq_datapath.sv
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers, entry count, entry store and result registers.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dq_pkg::dq_cmd_t               cmd,
    input  logic [dq_pkg::OP_W-1:0]       opcode,
    input  logic [dq_pkg::WORD_W-1:0]     push_value,
    output logic [dq_pkg::WORD_W-1:0]     read_value,
    output logic [dq_pkg::STATUS_W-1:0]   status,
    output logic                          now_empty,
    output logic [dq_pkg::OCC_W-1:0]      occupancy
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [dq_pkg::OP_W-1:0]     op_reg;
    logic [dq_pkg::WORD_W-1:0]   push_value_reg;
    logic [IDX_W-1:0]            front_reg, front_next;
    logic [IDX_W-1:0]            back_reg, back_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [dq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                        rd_ok_reg, rd_ok_next;

    logic [IDX_W-1:0]      front_prev, front_succ, back_prev, back_succ;
    logic                  is_full, is_empty;
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_addr;
    logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [dq_pkg::WORD_W-1:0] rd_word;

    assign front_prev = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign front_succ = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign back_prev  = (back_reg == '0) ? IDX_LAST : back_reg - 1'b1;
    assign back_succ  = (back_reg == IDX_LAST) ? '0 : back_reg + 1'b1;
    assign is_full    = (count_reg == CNT_FULL);
    assign is_empty   = (count_reg == '0);

    always_comb
    begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = '0;
        if (cmd.exec)
        begin
            status_next = dq_pkg::ST_OK;
            rd_ok_next  = 1'b0;
            unique case (op_reg)
                dq_pkg::OP_PUSH_HEAD:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_next = front_prev;
                        ram_addr   = front_prev;
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::OP_PUSH_TAIL:
                begin
                    if (is_full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        back_next  = back_succ;
                        ram_addr   = back_reg;
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::OP_POP_HEAD, dq_pkg::OP_PEEK_HEAD:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ram_addr   = front_reg;
                        ram_re     = 1'b1;
                        rd_ok_next = 1'b1;
                        if (op_reg == dq_pkg::OP_POP_HEAD)
                        begin
                            front_next = front_succ;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                dq_pkg::OP_POP_TAIL, dq_pkg::OP_PEEK_TAIL:
                begin
                    if (is_empty)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ram_addr   = back_prev;
                        ram_re     = 1'b1;
                        rd_ok_next = 1'b1;
                        if (op_reg == dq_pkg::OP_POP_TAIL)
                        begin
                            back_next  = back_prev;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg         <= opcode;
            push_value_reg <= push_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg  <= '0;
            back_reg   <= '0;
            count_reg  <= '0;
            status_reg <= dq_pkg::ST_OK;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            front_reg  <= front_next;
            back_reg   <= back_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            rd_ok_reg  <= rd_ok_next;
        end
    end

    generate
        if (DATA_WIDTH >= dq_pkg::WORD_W)
        begin : g_wide
            assign rd_word = ram_rdata[dq_pkg::WORD_W-1:0];
        end
        else
        begin : g_narrow
            assign rd_word = {{(dq_pkg::WORD_W - DATA_WIDTH){1'b0}}, ram_rdata};
        end
        if (DATA_WIDTH <= dq_pkg::WORD_W)
        begin : g_wr_narrow
            assign ram_wdata = push_value_reg[DATA_WIDTH-1:0];
        end
        else
        begin : g_wr_wide
            assign ram_wdata = {{(DATA_WIDTH - dq_pkg::WORD_W){1'b0}}, push_value_reg};
        end
        if (CNT_W >= dq_pkg::OCC_W)
        begin : g_occ_wide
            assign occupancy = count_reg[dq_pkg::OCC_W-1:0];
        end
        else
        begin : g_occ_narrow
            assign occupancy = {{(dq_pkg::OCC_W - CNT_W){1'b0}}, count_reg};
        end
    endgenerate

    dq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign read_value = rd_ok_reg ? rd_word : '0;
    assign status     = status_reg;
    assign now_empty  = is_empty;

endmodule

// File: rtl/double_ended_queue_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of data words held in a ring buffer.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (opcode, push_value) and each one gives
// exactly one result on the rsp channel (read_value, status, now_empty,
// occupancy). Both channels use valid/ready; a transfer happens on a rising
// edge with both high.
// A request is taken in the idle state, executed in the exec state (pointer
// update and one access to the entry RAM), and its result, registered at the
// end of execution, is offered from the response state on. One request is
// handled at a time: no new request is taken until the result has been
// transferred, and the sequencer takes, executes and offers each request in
// a state of its own.
// While the receiver holds rsp.ready low the result is held steady and
// req.ready stays low. Reset empties the queue at once; entry contents are
// not cleared and are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    dq_pkg::dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    dq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (req.opcode),
        .push_value (req.push_value),
        .read_value (rsp.read_value),
        .status     (rsp.status),
        .now_empty  (rsp.now_empty),
        .occupancy  (rsp.occupancy)
    );

`ifndef ASSERT_OFF
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(rsp.valid && req.ready))
        else $error("Request accepted while a result is pending.");

    a_full_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == dq_pkg::ST_FULL)) |-> (rsp.read_value == '0))
        else $error("Refused push returned a non-zero word.");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == dq_pkg::ST_EMPTY)) |-> rsp.now_empty)
        else $error("Empty status reported with a non-empty queue.");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |=> !rsp.valid)
        else $error("Result offered again after its transfer.");
`endif

endmodule
